>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion wrappers used by the address table core. Define
// ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge, ignored while reset is high
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Checked on every rising edge, reset included
`define ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) (prop)) \
      else $error("%m: assertion failed");

`else

`define ASSERT_CLK(name, clk, rst, prop)
`define ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

>>> sv/atle_pkg.sv
// ----------------------------------------------------------------------------
// Address table LRU eviction package
// Sizes, opcodes and payload types of the device address table.
// ----------------------------------------------------------------------------
package atle_pkg;

   // Table geometry
   localparam int MAX_ENTRIES = 16;
   localparam int NUM_TYPES   = 8;
   localparam int SLOT_W      = $clog2(MAX_ENTRIES);
   localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
   localparam int ADDR_W      = 48;
   localparam int EPOCH_W     = 32;
   localparam int MASK_W      = 16;

   // Opcodes
   localparam logic [2:0] OP_SEEN    = 3'd0;
   localparam logic [2:0] OP_BLOCK   = 3'd1;
   localparam logic [2:0] OP_UNBLOCK = 3'd2;
   localparam logic [2:0] OP_DELETE  = 3'd3;
   localparam logic [2:0] OP_MARK    = 3'd4;
   localparam logic [2:0] OP_READ    = 3'd5;
   localparam logic [2:0] OP_CLEAR   = 3'd6;

   // Request payload
   typedef struct packed {
      logic [2:0]        opcode;
      logic [ADDR_W-1:0] device_addr;
      logic [3:0]        slot_index;
      logic [3:0]        type_code;
   } req_type;

   // Response payload
   typedef struct packed {
      logic               found;
      logic               created;
      logic               evicted;
      logic [3:0]         slot;
      logic [ADDR_W-1:0]  entry_addr;
      logic               entry_active;
      logic [EPOCH_W-1:0] entry_last_seen;
      logic [MASK_W-1:0]  entry_type_mask;
      logic               newly_marked;
      logic [4:0]         entry_count;
   } rsp_type;

   // One table record
   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic               active;
      logic [EPOCH_W-1:0] last_seen;
      logic [MASK_W-1:0]  type_mask;
   } entry_type;

   // Comparator result
   typedef struct packed {
      logic eq;
      logic lt;
   } cmp_res_type;

   // Copy a record into the entry fields of a response
   function automatic rsp_type put_entry(input rsp_type r, input entry_type e);
      rsp_type o;
      o                 = r;
      o.entry_addr      = e.addr;
      o.entry_active    = e.active;
      o.entry_last_seen = e.last_seen;
      o.entry_type_mask = e.type_mask;
      return o;
   endfunction

endpackage

>>> sv/atle_entry_ram.sv
// ----------------------------------------------------------------------------
// Entry RAM
// Table records, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module atle_entry_ram
   import atle_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [SLOT_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [SLOT_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem [MAX_ENTRIES];
   entry_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/atle_cmp_unit.sv
// ----------------------------------------------------------------------------
// Shared compare unit
// One 48-bit magnitude comparator, used for address match during lookup
// and for last-seen ordering during the victim search.
// ----------------------------------------------------------------------------
module atle_cmp_unit
   import atle_pkg::*;
(
   input  logic              victim_mode,
   input  entry_type         entry,
   input  logic [ADDR_W-1:0] key_addr,
   input  logic [EPOCH_W-1:0] best_epoch,
   output cmp_res_type       res
);

   logic [ADDR_W-1:0] op_a;
   logic [ADDR_W-1:0] op_b;

   // Operand select: epochs are zero extended onto the address width
   always_comb begin
      if (victim_mode) begin
         op_a = ADDR_W'(entry.last_seen);
         op_b = ADDR_W'(best_epoch);
      end else begin
         op_a = entry.addr;
         op_b = key_addr;
      end
   end

   assign res.eq = (op_a == op_b);
   assign res.lt = (op_a < op_b);

endmodule

>>> sv/address_table_lru_evict_core.sv
// ----------------------------------------------------------------------------
// Address table with least-recently-seen eviction
// Keeps up to sixteen device records and serves seen, block, unblock,
// delete, mark type, read slot and clear requests one at a time.
//
//   channel  ports                          direction
//   request  req_valid req_stall req_data   in  (req_stall driven here)
//   response rsp_valid rsp_stall rsp_data   out (rsp_stall driven by sink)
//   config   csr_wr_en csr_wr_data          in  (boot epoch, write only)
//
// One request at a time; a lookup reads and compares the records in turn
// through the single RAM read port and the shared comparator.
// Lookup: searches the occupied slots in order; a miss on a full table adds
// a victim scan over all sixteen slots before the response.
// Mark type and read slot read the record on an occupied slot, then respond;
// on an empty slot, and for clear and unknown opcodes, they respond directly.
// No clearing pass after reset: slots at or above the count are never read.
// req_stall stays high from acceptance until the response transfer.
// ----------------------------------------------------------------------------
module address_table_lru_evict_core
   import atle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   // configuration
   input  logic               csr_wr_en,
   input  logic [EPOCH_W-1:0] csr_wr_data
);

`include "assert_macros.svh"

   // Sequencer states
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_RD_M  = 4'd1;
   localparam logic [3:0] ST_CMP_M = 4'd2;
   localparam logic [3:0] ST_DEL_W = 4'd3;
   localparam logic [3:0] ST_MISS  = 4'd4;
   localparam logic [3:0] ST_RD_V  = 4'd5;
   localparam logic [3:0] ST_CMP_V = 4'd6;
   localparam logic [3:0] ST_RPT   = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;

   logic [3:0]         state_ff,      state_in;
   logic [COUNT_W-1:0] occ_ff,        occ_in;
   logic [EPOCH_W-1:0] epoch_ff,      epoch_in;
   req_type            req_ff,        req_in;
   logic [SLOT_W-1:0]  idx_ff,        idx_in;
   logic [SLOT_W-1:0]  best_slot_ff,  best_slot_in;
   logic [EPOCH_W-1:0] best_epoch_ff, best_epoch_in;
   rsp_type            rsp_ff,        rsp_in;

   logic               wr_en;
   logic [SLOT_W-1:0]  wr_addr;
   entry_type          wr_data;
   logic [SLOT_W-1:0]  rd_addr;
   entry_type          rd_data;

   logic               cmp_victim;
   cmp_res_type        cmp_res;

   logic [COUNT_W-1:0] occ_dec;
   logic [SLOT_W-1:0]  last_slot;
   logic               full;
   entry_type          new_entry;
   entry_type          upd_entry;
   logic               take_victim;
   logic [SLOT_W-1:0]  victim_slot;
   logic [MASK_W-1:0]  type_bit;
   logic               type_ok;

   // Record storage
   atle_entry_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Shared comparator
   atle_cmp_unit u_cmp (
      .victim_mode (cmp_victim),
      .entry       (rd_data),
      .key_addr    (req_ff.device_addr),
      .best_epoch  (best_epoch_ff),
      .res         (cmp_res)
   );

   // Helpers
   assign occ_dec     = occ_ff - COUNT_W'(1);
   assign last_slot   = occ_dec[SLOT_W-1:0];
   assign full        = (occ_ff == COUNT_W'(MAX_ENTRIES));
   assign take_victim = (idx_ff == '0) || cmp_res.lt;
   assign victim_slot = take_victim ? idx_ff : best_slot_ff;
   assign type_bit    = MASK_W'(1) << req_ff.type_code;
   assign type_ok     = (5'(req_ff.type_code) < 5'(NUM_TYPES));

   always_comb begin
      new_entry.addr      = req_ff.device_addr;
      new_entry.active    = 1'b1;
      new_entry.last_seen = epoch_ff;
      new_entry.type_mask = '0;
   end

   // Configuration register
   assign epoch_in = csr_wr_en ? csr_wr_data : epoch_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      occ_in        = occ_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      best_slot_in  = best_slot_ff;
      best_epoch_in = best_epoch_ff;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data;
      rd_addr       = idx_ff;
      cmp_victim    = 1'b0;
      upd_entry     = rd_data;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               rsp_in = '0;
               idx_in = '0;
               case (req_data.opcode)
                  OP_SEEN, OP_BLOCK, OP_UNBLOCK, OP_DELETE: begin
                     state_in = ST_RD_M;
                  end
                  OP_MARK, OP_READ: begin
                     rd_addr = req_data.slot_index;
                     if (COUNT_W'(req_data.slot_index) < occ_ff) begin
                        state_in = ST_RPT;
                     end else begin
                        state_in = ST_OUT;
                     end
                  end
                  OP_CLEAR: begin
                     occ_in   = '0;
                     state_in = ST_OUT;
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end
         end

         // Lookup: read one slot
         ST_RD_M: begin
            if (occ_ff == '0) begin
               state_in = ST_MISS;
            end else begin
               state_in = ST_CMP_M;
            end
         end

         // Lookup: compare the slot read last cycle
         ST_CMP_M: begin
            if (cmp_res.eq) begin
               rsp_in.found = 1'b1;
               rsp_in.slot  = idx_ff;
               state_in     = ST_OUT;
               case (req_ff.opcode)
                  OP_SEEN: begin
                     upd_entry.last_seen = epoch_ff;
                     wr_en   = 1'b1;
                     wr_data = upd_entry;
                     rsp_in  = put_entry(rsp_in, upd_entry);
                  end
                  OP_BLOCK, OP_UNBLOCK: begin
                     upd_entry.active = (req_ff.opcode == OP_UNBLOCK);
                     wr_en   = 1'b1;
                     wr_data = upd_entry;
                     rsp_in  = put_entry(rsp_in, upd_entry);
                  end
                  OP_DELETE: begin
                     occ_in = occ_dec;
                     if (idx_ff != last_slot) begin
                        rd_addr  = last_slot;
                        state_in = ST_DEL_W;
                     end
                  end
                  default: begin
                     state_in = ST_OUT;
                  end
               endcase
            end else if (idx_ff == last_slot) begin
               state_in = ST_MISS;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = ST_RD_M;
            end
         end

         // Delete: move the last record into the freed slot
         ST_DEL_W: begin
            wr_en    = 1'b1;
            wr_data  = rd_data;
            rsp_in   = put_entry(rsp_in, rd_data);
            state_in = ST_OUT;
         end

         // No match: append, start the victim search, or report not found
         ST_MISS: begin
            state_in = ST_OUT;
            if (req_ff.opcode == OP_SEEN) begin
               if (full) begin
                  idx_in   = '0;
                  state_in = ST_RD_V;
               end else begin
                  wr_en          = 1'b1;
                  wr_addr        = occ_ff[SLOT_W-1:0];
                  wr_data        = new_entry;
                  occ_in         = occ_ff + COUNT_W'(1);
                  rsp_in.created = 1'b1;
                  rsp_in.slot    = occ_ff[SLOT_W-1:0];
                  rsp_in         = put_entry(rsp_in, new_entry);
               end
            end
         end

         // Victim search: read one slot
         ST_RD_V: begin
            state_in = ST_CMP_V;
         end

         // Victim search: keep the lowest last-seen, first slot on ties
         ST_CMP_V: begin
            cmp_victim = 1'b1;
            if (take_victim) begin
               best_slot_in  = idx_ff;
               best_epoch_in = rd_data.last_seen;
            end
            if (idx_ff == SLOT_W'(MAX_ENTRIES - 1)) begin
               wr_en          = 1'b1;
               wr_addr        = victim_slot;
               wr_data        = new_entry;
               rsp_in.created = 1'b1;
               rsp_in.evicted = 1'b1;
               rsp_in.slot    = victim_slot;
               rsp_in         = put_entry(rsp_in, new_entry);
               state_in       = ST_OUT;
            end else begin
               idx_in   = idx_ff + SLOT_W'(1);
               state_in = ST_RD_V;
            end
         end

         // Mark type or read slot on the record read at acceptance
         ST_RPT: begin
            rsp_in.found = 1'b1;
            rsp_in.slot  = req_ff.slot_index;
            wr_addr      = req_ff.slot_index;
            if ((req_ff.opcode == OP_MARK) && type_ok &&
                ((rd_data.type_mask & type_bit) == '0)) begin
               upd_entry.type_mask = rd_data.type_mask | type_bit;
               wr_en               = 1'b1;
               wr_data             = upd_entry;
               rsp_in.newly_marked = 1'b1;
            end
            rsp_in   = put_entry(rsp_in, upd_entry);
            state_in = ST_OUT;
         end

         // Hold the result until the transfer
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         occ_ff   <= '0;
         epoch_ff <= '0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         epoch_ff <= epoch_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      best_slot_ff  <= best_slot_in;
      best_epoch_ff <= best_epoch_in;
      rsp_ff        <= rsp_in;
   end

   // Ports
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);

   always_comb begin
      rsp_data             = rsp_ff;
      rsp_data.entry_count = occ_ff;
   end

   // Checks
   `ASSERT_CLK(a_occ_bound, clock, reset, occ_ff <= COUNT_W'(MAX_ENTRIES))
   `ASSERT_CLK(a_no_accept_while_busy, clock, reset, (req_valid && !req_stall) |-> !rsp_valid)
   `ASSERT_CLK(a_scan_in_range, clock, reset, (state_ff == ST_CMP_M) |-> (COUNT_W'(idx_ff) < occ_ff))
   `ASSERT_CLK(a_evict_when_full, clock, reset, (rsp_valid && rsp_data.evicted) |-> (rsp_data.created && full))
   `ASSERT_CLK(a_found_or_created, clock, reset, rsp_valid |-> !(rsp_data.found && rsp_data.created))

endmodule

>>> tb/address_table_lru_evict_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Address table LRU eviction testbench
// Sends requests to the address table and checks every response against a
// shadow table kept in the testbench. The run has a directed pass over the
// corner cases, random traffic across many boot epochs, one long response
// hold-off and a tail with no idle cycles.
// ----------------------------------------------------------------------------
module address_table_lru_evict_core_tb;
   import atle_pkg::*;

   localparam logic [2:0] OP_NOP = 3'd7;
   localparam int POOL_SIZE   = 24;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_PAD    = 4;
   localparam int DRAIN_PAD   = 100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   req_type            req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   rsp_type            rsp_data;
   logic               csr_wr_en = 1'b0;
   logic [EPOCH_W-1:0] csr_wr_data = '0;

   // Shadow copy of the table and the boot epoch
   logic [ADDR_W-1:0]  shadow_addr   [MAX_ENTRIES];
   logic               shadow_active [MAX_ENTRIES];
   logic [EPOCH_W-1:0] shadow_seen   [MAX_ENTRIES];
   logic [MASK_W-1:0]  shadow_mask   [MAX_ENTRIES];
   int                 shadow_count;
   logic [EPOCH_W-1:0] shadow_epoch;

   req_type            pending_reqs [$];
   rsp_type            expected_rsps [$];
   logic [ADDR_W-1:0]  addr_pool [POOL_SIZE];
   int                 gap_left = 0;
   int                 err_count = 0;
   bit                 src_gaps = 1'b1;
   bit                 sink_gaps = 1'b1;
   bit                 hold_req = 1'b0;

   address_table_lru_evict_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Shadow table
   // ---------------------------------------------------------------------
   function automatic void wipe_shadow();
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         shadow_addr[i]   = '0;
         shadow_active[i] = 1'b0;
         shadow_seen[i]   = '0;
         shadow_mask[i]   = '0;
      end
      shadow_count = 0;
   endfunction

   function automatic int find_addr(input logic [ADDR_W-1:0] a);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_addr[i] == a) return i;
      return -1;
   endfunction

   function automatic rsp_type with_entry(input rsp_type r, input int s);
      rsp_type o;
      o                 = r;
      o.slot            = s[3:0];
      o.entry_addr      = shadow_addr[s];
      o.entry_active    = shadow_active[s];
      o.entry_last_seen = shadow_seen[s];
      o.entry_type_mask = shadow_mask[s];
      return o;
   endfunction

   // Apply one request to the shadow table and return the expected response
   function automatic rsp_type apply_op(input req_type r);
      rsp_type o;
      int      hit;
      int      s;
      int      last;
      o   = '0;
      s   = 0;
      hit = find_addr(r.device_addr);
      case (r.opcode)
         OP_SEEN: begin
            if (hit >= 0) begin
               s = hit;
               shadow_seen[s] = shadow_epoch;
               o.found = 1'b1;
            end else begin
               if (shadow_count >= MAX_ENTRIES) begin
                  // oldest last-seen wins, lowest slot on ties
                  for (int i = 1; i < MAX_ENTRIES; i++)
                     if (shadow_seen[i] < shadow_seen[s]) s = i;
                  o.evicted = 1'b1;
               end else begin
                  s = shadow_count;
                  shadow_count++;
               end
               shadow_addr[s]   = r.device_addr;
               shadow_active[s] = 1'b1;
               shadow_seen[s]   = shadow_epoch;
               shadow_mask[s]   = '0;
               o.created = 1'b1;
            end
            o = with_entry(o, s);
         end
         OP_BLOCK, OP_UNBLOCK: begin
            if (hit >= 0) begin
               shadow_active[hit] = (r.opcode == OP_UNBLOCK);
               o.found = 1'b1;
               o = with_entry(o, hit);
            end
         end
         OP_DELETE: begin
            // last entry fills the hole, old last slot is zeroed
            if (hit >= 0) begin
               last = shadow_count - 1;
               shadow_addr[hit]    = shadow_addr[last];
               shadow_active[hit]  = shadow_active[last];
               shadow_seen[hit]    = shadow_seen[last];
               shadow_mask[hit]    = shadow_mask[last];
               shadow_addr[last]   = '0;
               shadow_active[last] = 1'b0;
               shadow_seen[last]   = '0;
               shadow_mask[last]   = '0;
               shadow_count = last;
               o.found = 1'b1;
               o = with_entry(o, hit);
            end
         end
         OP_MARK: begin
            if (r.slot_index < shadow_count) begin
               if (r.type_code < NUM_TYPES && !shadow_mask[r.slot_index][r.type_code]) begin
                  shadow_mask[r.slot_index][r.type_code] = 1'b1;
                  o.newly_marked = 1'b1;
               end
               o.found = 1'b1;
               o = with_entry(o, int'(r.slot_index));
            end
         end
         OP_READ: begin
            if (r.slot_index < shadow_count) begin
               o.found = 1'b1;
               o = with_entry(o, int'(r.slot_index));
            end
         end
         OP_CLEAR: wipe_shadow();
         default: ;
      endcase
      o.entry_count = shadow_count[4:0];
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [ADDR_W-1:0] rand_addr();
      logic [63:0] v;
      v = {$urandom, $urandom};
      return v[ADDR_W-1:0];
   endfunction

   function automatic req_type make_req(input logic [2:0] op, input logic [ADDR_W-1:0] a,
                                        input logic [3:0] si, input logic [3:0] tc);
      req_type r;
      r.opcode      = op;
      r.device_addr = a;
      r.slot_index  = si;
      r.type_code   = tc;
      return r;
   endfunction

   // Mostly pooled addresses so lookups hit and the table fills and evicts
   function automatic req_type rand_req();
      int               pick;
      logic [2:0]       op;
      logic [ADDR_W-1:0] a;
      pick = $urandom_range(0, 99);
      if (pick < 40)      op = OP_SEEN;
      else if (pick < 48) op = OP_BLOCK;
      else if (pick < 56) op = OP_UNBLOCK;
      else if (pick < 66) op = OP_DELETE;
      else if (pick < 80) op = OP_MARK;
      else if (pick < 95) op = OP_READ;
      else if (pick < 97) op = OP_CLEAR;
      else                op = OP_NOP;
      if ($urandom_range(0, 6) == 0) a = rand_addr();
      else                           a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      return make_req(op, a, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
   endfunction

   task automatic report_mismatch(input string msg);
      err_count++;
      $display("%0t: mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   // Queue one request; returns once no earlier request is still queued
   task automatic send_req(input req_type r);
      pending_reqs.push_back(r);
      while (pending_reqs.size() > 1) @(posedge clock);
   endtask

   // Wait for all traffic to drain, then a few quiet cycles
   task automatic wait_idle();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (IDLE_PAD) @(posedge clock);
   endtask

   task automatic set_epoch(input logic [EPOCH_W-1:0] v);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      shadow_epoch = v;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: predicts each transfer, inserts random idle bursts
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(apply_op(req_data));
            void'(pending_reqs.pop_front());
         end
         // a stalled request holds until its transfer
         if (!(req_valid && req_stall)) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0 && src_gaps && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response sink: random stall bursts and one long hold-off on request
   // ---------------------------------------------------------------------
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Response checker
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("response transfer with nothing expected");
         end else begin
            want = expected_rsps.pop_front();
            check_field("found", 64'(rsp_data.found), 64'(want.found));
            check_field("created", 64'(rsp_data.created), 64'(want.created));
            check_field("evicted", 64'(rsp_data.evicted), 64'(want.evicted));
            check_field("slot", 64'(rsp_data.slot), 64'(want.slot));
            check_field("entry_addr", 64'(rsp_data.entry_addr), 64'(want.entry_addr));
            check_field("entry_active", 64'(rsp_data.entry_active),
                        64'(want.entry_active));
            check_field("entry_last_seen", 64'(rsp_data.entry_last_seen),
                        64'(want.entry_last_seen));
            check_field("entry_type_mask", 64'(rsp_data.entry_type_mask),
                        64'(want.entry_type_mask));
            check_field("newly_marked", 64'(rsp_data.newly_marked),
                        64'(want.newly_marked));
            check_field("entry_count", 64'(rsp_data.entry_count),
                        64'(want.entry_count));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic run_directed_ops();
      logic [ADDR_W-1:0] addr_lo;
      logic [ADDR_W-1:0] addr_hi;
      logic [ADDR_W-1:0] addr_mid;
      addr_lo  = '0;
      addr_hi  = '1;
      addr_mid = 48'h5555_AAAA_0F0F;
      // empty table: nothing to find, then a clear and a first create
      send_req(make_req(OP_READ,    addr_lo, 4'd0, 4'd0));
      send_req(make_req(OP_MARK,    addr_lo, 4'd0, 4'd0));
      send_req(make_req(OP_BLOCK,   addr_lo, 4'd0, 4'd0));
      send_req(make_req(OP_DELETE,  addr_lo, 4'd0, 4'd0));
      send_req(make_req(OP_NOP,     addr_hi, 4'd15, 4'd15));
      send_req(make_req(OP_CLEAR,   addr_hi, 4'd0, 4'd0));
      send_req(make_req(OP_SEEN,    addr_lo, 4'd0, 4'd0));
      set_epoch('1);
      // create, hit, block and unblock
      send_req(make_req(OP_SEEN,    addr_hi, 4'd0, 4'd0));
      send_req(make_req(OP_SEEN,    addr_lo, 4'd0, 4'd0));
      send_req(make_req(OP_SEEN,    addr_mid, 4'd0, 4'd0));
      send_req(make_req(OP_BLOCK,   addr_hi, 4'd0, 4'd0));
      send_req(make_req(OP_UNBLOCK, addr_hi, 4'd0, 4'd0));
      // type marks: new bit, top legal bit, repeat, rejected codes
      send_req(make_req(OP_MARK,    addr_lo, 4'd1, 4'd0));
      send_req(make_req(OP_MARK,    addr_lo, 4'd1, 4'(NUM_TYPES - 1)));
      send_req(make_req(OP_MARK,    addr_lo, 4'd1, 4'd0));
      send_req(make_req(OP_MARK,    addr_lo, 4'd1, 4'(NUM_TYPES)));
      send_req(make_req(OP_MARK,    addr_lo, 4'd2, 4'd15));
      // reads inside and past the count
      send_req(make_req(OP_READ,    addr_lo, 4'd1, 4'd0));
      send_req(make_req(OP_READ,    addr_lo, 4'd15, 4'd0));
      send_req(make_req(OP_READ,    addr_lo, 4'd3, 4'd0));
      // delete with a move, then delete of the last entry
      send_req(make_req(OP_DELETE,  addr_hi, 4'd0, 4'd0));
      send_req(make_req(OP_DELETE,  addr_mid, 4'd0, 4'd0));
      send_req(make_req(OP_UNBLOCK, addr_mid, 4'd0, 4'd0));
      send_req(make_req(OP_CLEAR,   addr_lo, 4'd0, 4'd0));
   endtask

   // Phases of random traffic, each under its own boot epoch
   task automatic run_random_traffic();
      logic [EPOCH_W-1:0] next_epoch;
      int                 pick;
      next_epoch = 32'd1;
      for (int p = 0; p < 26; p++) begin
         pick = $urandom_range(0, 7);
         if (pick == 0)      next_epoch = '0;
         else if (pick == 1) next_epoch = '1;
         else if (pick == 2) next_epoch = $urandom;
         else                next_epoch = next_epoch + $urandom_range(1, 3);
         set_epoch(next_epoch);
         repeat ($urandom_range(20, 30)) send_req(rand_req());
      end
   endtask

   // Long response hold-off while requests keep coming
   task automatic run_response_holdoff();
      hold_req = 1'b1;
      repeat (6) send_req(rand_req());
   endtask

   // Back-to-back traffic with no idle cycles on either side
   task automatic run_steady_tail();
      src_gaps  = 1'b0;
      sink_gaps = 1'b0;
      set_epoch($urandom);
      repeat (100) send_req(rand_req());
   endtask

   initial begin
      wipe_shadow();
      shadow_epoch = '0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = rand_addr();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed_ops();
      run_random_traffic();
      run_response_holdoff();
      run_steady_tail();
      wait_idle();
      repeat (DRAIN_PAD) @(posedge clock);
      if (err_count == 0) $display("PASS");
      else                $display("FAIL");
      $finish;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
